// ----- rtl/core/mhcp_pkg.sv -----
// mhcp_pkg: shared types and constant tables of the heater current pwm unit
// used by the top level, the divide unit and the port checker; no dependencies
`default_nettype none

package mhcp_pkg;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_SET     = 2'd1,
		CMD_ENABLE  = 2'd2,
		CMD_DISABLE = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [2:0]  channel;
		logic [15:0] current_request;
		logic [7:0]  adc_sample;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] heater_pins;
		logic [5:0] adc_mux_code;
		logic [7:0] enabled_mask;
		logic       overcurrent_trip;
	} rsp_item_t;

	// divide unit request and status
	typedef struct packed {
		logic       start;
		logic [7:0] num;
		logic [7:0] den;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [3:0] quot;
	} div_rsp_t;

	localparam int unsigned NUM_CH    = 8;
	localparam int unsigned NUM_WORDS = 128;

	localparam logic [1:0] TRIP_BITS = 2'b11; // sample bits 7:6, i.e. 0xc0

	localparam logic [15:0] LEVEL_TABLE [NUM_WORDS] = '{
		16'h0001, 16'h0101, 16'h0111, 16'h1111, 16'h1115, 16'h1515, 16'h1555, 16'h5555,
		16'h5557, 16'h5757, 16'h5777, 16'h7777, 16'h777f, 16'h7f7f, 16'h7fff, 16'hffff,
		16'h0002, 16'h0202, 16'h0222, 16'h2222, 16'h222a, 16'h2a2a, 16'h2aaa, 16'haaaa,
		16'haaae, 16'haeae, 16'haeee, 16'heeee, 16'heeef, 16'hefef, 16'hefff, 16'hffff,
		16'h0004, 16'h0404, 16'h0444, 16'h4444, 16'h4454, 16'h4545, 16'h4555, 16'h5555,
		16'h5557, 16'h5757, 16'h5777, 16'h7777, 16'h777f, 16'h7f7f, 16'h7fff, 16'hffff,
		16'h0008, 16'h0808, 16'h0888, 16'h8888, 16'h88a8, 16'h8a8a, 16'h8aaa, 16'haaaa,
		16'haaae, 16'haeae, 16'haeee, 16'heeee, 16'heeef, 16'hefef, 16'hefff, 16'hffff,
		16'h0010, 16'h1010, 16'h1110, 16'h1111, 16'h1511, 16'h1515, 16'h1555, 16'h5555,
		16'h5557, 16'h5757, 16'h5777, 16'h7777, 16'h777f, 16'h7f7f, 16'h7fff, 16'hffff,
		16'h0020, 16'h2020, 16'h2220, 16'h2222, 16'h2a22, 16'h2a2a, 16'h2aaa, 16'haaaa,
		16'haaae, 16'haeae, 16'haeee, 16'heeee, 16'heeef, 16'hefef, 16'hefff, 16'hffff,
		16'h0040, 16'h4040, 16'h4440, 16'h4444, 16'h5444, 16'h4545, 16'h4555, 16'h5555,
		16'h5557, 16'h5757, 16'h5777, 16'h7777, 16'h777f, 16'h7f7f, 16'h7fff, 16'hffff,
		16'h0080, 16'h8080, 16'h8880, 16'h8888, 16'ha888, 16'h8a8a, 16'h8aaa, 16'haaaa,
		16'haaae, 16'haeae, 16'haeee, 16'heeee, 16'heeef, 16'hefef, 16'hefff, 16'hffff
	};

	localparam logic [5:0] MUX_TABLE [NUM_CH] = '{
		6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h07, 6'h06
	};

endpackage

`default_nettype wire

// ----- rtl/core/multichannel_heater_current_pwm_unit.sv -----
// multichannel_heater_current_pwm_unit: eight-channel heater current regulator, slotted pwm
// depends on mhcp_pkg and mhcp_div
// set, enable and disable items are taken while idle and give no result
// a tick on which the divide runs goes through the divide, update and emit states, any other
// tick through update and emit; the divide state ends on the done flag after the four divide
// steps on the shared compare/subtract unit; cmd_ready is low from a tick's acceptance until
// its result is loaded, and the load waits while a stalled result holds the output register
// arst_n clears all targets, patterns, enables, the scan position and the half select
`default_nettype none

module multichannel_heater_current_pwm_unit #(
	parameter int unsigned CHANNELS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output      logic                 cmd_ready,
	input  wire mhcp_pkg::cmd_item_t  cmd_data,
	output      logic                 rsp_valid,
	input  wire logic                 rsp_ready,
	output      mhcp_pkg::rsp_item_t  rsp_data
);
	import mhcp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD,
		ST_EMIT
	} state_t;

	state_t     state_q;

	// per channel store
	logic [6:0] target_q  [CHANNELS];
	logic [7:0] pat_lo_q  [CHANNELS];
	logic [7:0] pat_hi_q  [CHANNELS];
	logic [7:0] enabled_q;

	// scan position; armed_q low until the first tick, so that tick checks nothing
	logic [2:0] scan_q;
	logic       armed_q;
	logic       half_q;

	// what the accepted tick does to the scanned channel
	logic       trip_q;
	logic       div_q;

	logic       rsp_valid_q;
	rsp_item_t  rsp_q;

	div_req_t   div_req;
	div_rsp_t   div_rsp;

	logic       accept;
	logic       is_tick;
	logic       chan_ok;
	logic       check;
	logic       over;
	logic [6:0] targ_sel;
	logic [6:0] new_targ;
	logic [15:0] upd_word;
	logic [7:0] pins;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign is_tick   = (cmd_data.command == CMD_TICK);
	assign chan_ok   = ({1'b0, cmd_data.channel} < 4'(CHANNELS));
	assign check     = armed_q && enabled_q[scan_q];
	assign over      = (cmd_data.adc_sample[7:6] & TRIP_BITS) != 2'b00;
	assign new_targ  = cmd_data.current_request[8:2];
	assign upd_word  = LEVEL_TABLE[{scan_q, div_rsp.quot}];

	// target of the scanned channel for the divide
	always_comb begin
		targ_sel = 7'd0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (scan_q == 3'(i)) begin
				targ_sel = target_q[i];
			end
		end
	end

	// pin levels at the current slot, from the half chosen by half_q
	always_comb begin
		pins = 8'd0;
		for (int i = 0; i < CHANNELS; i++) begin
			pins[i] = half_q ? pat_lo_q[i][scan_q] : pat_hi_q[i][scan_q];
		end
	end

	// divide only on a checked, non-tripping tick in the high half
	always_comb begin
		div_req.start = accept && is_tick && check && !over && half_q;
		div_req.num   = {1'b0, targ_sel};
		div_req.den   = cmd_data.adc_sample;
	end

	mhcp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			enabled_q   <= 8'd0;
			scan_q      <= 3'd0;
			armed_q     <= 1'b0;
			half_q      <= 1'b0;
			trip_q      <= 1'b0;
			div_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				target_q[i] <= 7'd0;
				pat_lo_q[i] <= 8'd0;
				pat_hi_q[i] <= 8'd0;
			end
		end else begin
			// result taken downstream; a load in ST_EMIT sets valid itself
			if (rsp_valid_q && rsp_ready && state_q != ST_EMIT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_tick) begin
							trip_q  <= check && over;
							div_q   <= check && !over && half_q;
							state_q <= (check && !over && half_q) ? ST_DIV : ST_UPD;
						end else if (chan_ok) begin
							for (int i = 0; i < CHANNELS; i++) begin
								if (cmd_data.channel == 3'(i)) begin
									case (cmd_data.command)
										CMD_SET: begin
											if (cmd_data.current_request != 16'd0) begin
												// store target, then act as enable
												target_q[i] <= new_targ;
												pat_lo_q[i] <= (new_targ != 7'd0) ?
													LEVEL_TABLE[7'(i * 16)][7:0] : 8'd0;
												pat_hi_q[i] <= 8'd0;
												enabled_q[i] <= 1'b1;
											end else begin
												pat_lo_q[i] <= 8'd0;
												pat_hi_q[i] <= 8'd0;
												enabled_q[i] <= 1'b0;
											end
										end
										CMD_ENABLE: begin
											pat_lo_q[i] <= (target_q[i] != 7'd0) ?
												LEVEL_TABLE[7'(i * 16)][7:0] : 8'd0;
											pat_hi_q[i] <= 8'd0;
											enabled_q[i] <= 1'b1;
										end
										CMD_DISABLE: begin
											pat_lo_q[i] <= 8'd0;
											pat_hi_q[i] <= 8'd0;
											enabled_q[i] <= 1'b0;
										end
										default: begin
										end
									endcase
								end
							end
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					// apply trip or new pattern, then move to the next slot
					for (int i = 0; i < CHANNELS; i++) begin
						if (scan_q == 3'(i)) begin
							if (trip_q) begin
								pat_lo_q[i]  <= 8'd0;
								pat_hi_q[i]  <= 8'd0;
								enabled_q[i] <= 1'b0;
							end else if (div_q) begin
								pat_lo_q[i] <= upd_word[7:0];
								pat_hi_q[i] <= upd_word[15:8];
							end
						end
					end
					scan_q  <= scan_q + 3'd1;
					armed_q <= 1'b1;
					if (scan_q == 3'd7) begin
						half_q <= ~half_q;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// wait for the output register to be free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.heater_pins      <= pins;
						rsp_q.adc_mux_code     <= MUX_TABLE[scan_q];
						rsp_q.enabled_mask     <= enabled_q;
						rsp_q.overcurrent_trip <= trip_q;
						rsp_valid_q            <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/core/mhcp_div.sv -----
// mhcp_div: four-step restoring divide, one compare and subtract per cycle
// depends on mhcp_pkg for the request and status structs
`default_nettype none

module mhcp_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mhcp_pkg::div_req_t req,
	output      mhcp_pkg::div_rsp_t rsp
);
	import mhcp_pkg::*;

	logic [7:0] rem_q;
	logic [7:0] den_q;
	logic [3:0] quot_q;
	logic [1:0] step_q;
	logic       busy_q;
	logic       done_q;

	logic       take;
	logic [7:0] diff;
	logic [7:0] rem_nxt;

	// last step compares strictly, earlier steps also take on equal
	always_comb begin
		take    = (step_q == 2'd3) ? (rem_q > den_q) : (rem_q >= den_q);
		diff    = rem_q - den_q;
		rem_nxt = take ? diff : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= 4'd0;
		end else if (busy_q) begin
			rem_q  <= {rem_nxt[6:0], 1'b0};
			quot_q <= {quot_q[2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

// ----- rtl/core/mhcp_checker.sv -----
// mhcp_checker: port-level checks of the heater current pwm unit, bound to the top level
// depends on mhcp_pkg and multichannel_heater_current_pwm_unit
`default_nettype none

module mhcp_checker #(
	parameter int unsigned CHANNELS = 8
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cmd_valid,
	input wire logic                cmd_ready,
	input wire mhcp_pkg::cmd_item_t cmd_data,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire mhcp_pkg::rsp_item_t rsp_data
);
	import mhcp_pkg::*;

	localparam logic [7:0] CH_MASK = 8'((9'd1 << CHANNELS) - 9'd1);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// a tick keeps the block busy for the following cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_data.command == CMD_TICK |=> !cmd_ready)
		else $error("ready right after a tick");

	// only existing channels ever show as enabled or driven
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_data.enabled_mask & ~CH_MASK) == 8'd0)
			&& ((rsp_data.heater_pins & ~CH_MASK) == 8'd0))
		else $error("bit set for a missing channel");

	// the mux code comes from the fixed table
	a_mux_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.adc_mux_code == 6'h20 || rsp_data.adc_mux_code == 6'h21
			|| rsp_data.adc_mux_code == 6'h22 || rsp_data.adc_mux_code == 6'h23
			|| rsp_data.adc_mux_code == 6'h24 || rsp_data.adc_mux_code == 6'h25
			|| rsp_data.adc_mux_code == 6'h07 || rsp_data.adc_mux_code == 6'h06)
		else $error("mux code outside table");

endmodule

bind multichannel_heater_current_pwm_unit mhcp_checker #(.CHANNELS(CHANNELS)) u_mhcp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd_data  (cmd_data),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/tb_multichannel_heater_current_pwm_unit.sv -----
// tb_multichannel_heater_current_pwm_unit: self-checking bench for the heater current pwm unit
// depends on mhcp_pkg (item structs, command codes) and the multichannel_heater_current_pwm_unit rtl
// a slot predictor inside a scoreboard class checks every tick result under directed and random traffic

module tb_multichannel_heater_current_pwm_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mhcp_pkg::*;

	// pwm pattern words, sixteen duty levels per channel
	localparam logic [15:0] PWM_WORDS [128] = '{
		16'h0001, 16'h0101, 16'h0111, 16'h1111, 16'h1115, 16'h1515, 16'h1555, 16'h5555,
		16'h5557, 16'h5757, 16'h5777, 16'h7777, 16'h777f, 16'h7f7f, 16'h7fff, 16'hffff,
		16'h0002, 16'h0202, 16'h0222, 16'h2222, 16'h222a, 16'h2a2a, 16'h2aaa, 16'haaaa,
		16'haaae, 16'haeae, 16'haeee, 16'heeee, 16'heeef, 16'hefef, 16'hefff, 16'hffff,
		16'h0004, 16'h0404, 16'h0444, 16'h4444, 16'h4454, 16'h4545, 16'h4555, 16'h5555,
		16'h5557, 16'h5757, 16'h5777, 16'h7777, 16'h777f, 16'h7f7f, 16'h7fff, 16'hffff,
		16'h0008, 16'h0808, 16'h0888, 16'h8888, 16'h88a8, 16'h8a8a, 16'h8aaa, 16'haaaa,
		16'haaae, 16'haeae, 16'haeee, 16'heeee, 16'heeef, 16'hefef, 16'hefff, 16'hffff,
		16'h0010, 16'h1010, 16'h1110, 16'h1111, 16'h1511, 16'h1515, 16'h1555, 16'h5555,
		16'h5557, 16'h5757, 16'h5777, 16'h7777, 16'h777f, 16'h7f7f, 16'h7fff, 16'hffff,
		16'h0020, 16'h2020, 16'h2220, 16'h2222, 16'h2a22, 16'h2a2a, 16'h2aaa, 16'haaaa,
		16'haaae, 16'haeae, 16'haeee, 16'heeee, 16'heeef, 16'hefef, 16'hefff, 16'hffff,
		16'h0040, 16'h4040, 16'h4440, 16'h4444, 16'h5444, 16'h4545, 16'h4555, 16'h5555,
		16'h5557, 16'h5757, 16'h5777, 16'h7777, 16'h777f, 16'h7f7f, 16'h7fff, 16'hffff,
		16'h0080, 16'h8080, 16'h8880, 16'h8888, 16'ha888, 16'h8a8a, 16'h8aaa, 16'haaaa,
		16'haaae, 16'haeae, 16'haeee, 16'heeee, 16'heeef, 16'hefef, 16'hefff, 16'hffff
	};

	// converter input select per scan channel
	localparam logic [5:0] ADC_MUX [8] = '{
		6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h07, 6'h06
	};

	// slot predictor plus the queue of tick results still owed by the block
	class heater_pwm_scoreboard;
		bit [6:0]  target_lvl [8];
		bit [7:0]  pat_lo [8];
		bit [7:0]  pat_hi [8];
		bit [7:0]  en_bits;
		bit [2:0]  scan_ch;
		bit [7:0]  slot_sel;  // one-hot of the channel checked by the next tick, 0 after reset
		bit        half_sel;
		rsp_item_t slot_results_due [$];
		int        errors;

		// four-step restoring divide, remainder wraps at eight bits
		function bit [3:0] level_quotient(bit [7:0] num, bit [7:0] den);
			bit [7:0] rem;
			bit [3:0] q;
			rem = num;
			q = '0;
			for (int s = 3; s >= 1; s--) begin
				if (rem >= den) begin
					q[s] = 1'b1;
					rem = rem - den;
				end
				rem = rem << 1;
			end
			// last step uses a strict compare
			if (rem > den)
				q[0] = 1'b1;
			return q;
		endfunction

		function void switch_on(bit [2:0] ch);
			pat_lo[ch] = (target_lvl[ch] != 0) ? PWM_WORDS[{ch, 4'd0}][7:0] : 8'd0;
			pat_hi[ch] = '0;
			en_bits[ch] = 1'b1;
		endfunction

		function void switch_off(bit [2:0] ch);
			pat_lo[ch] = '0;
			pat_hi[ch] = '0;
			en_bits[ch] = 1'b0;
		endfunction

		// note an accepted item; ticks queue their predicted result
		function void take_command(cmd_item_t it);
			rsp_item_t  r;
			bit [15:0]  word;
			case (it.command)
				CMD_SET: begin
					// zero request acts as disable
					if (it.current_request != 0) begin
						target_lvl[it.channel] = it.current_request[8:2];
						switch_on(it.channel);
					end else begin
						switch_off(it.channel);
					end
				end
				CMD_ENABLE: begin
					switch_on(it.channel);
				end
				CMD_DISABLE: begin
					switch_off(it.channel);
				end
				default: begin
					r = '0;
					if ((en_bits & slot_sel) != 0) begin
						if (it.adc_sample[7:6] != 0) begin
							// overcurrent trips the scanned channel off
							pat_lo[scan_ch] = '0;
							pat_hi[scan_ch] = '0;
							en_bits = en_bits & ~slot_sel;
							r.overcurrent_trip = 1'b1;
						end else if (half_sel) begin
							word = PWM_WORDS[{scan_ch,
								level_quotient({1'b0, target_lvl[scan_ch]}, it.adc_sample)}];
							pat_lo[scan_ch] = word[7:0];
							pat_hi[scan_ch] = word[15:8];
						end
					end
					scan_ch = scan_ch + 3'd1;
					slot_sel = 8'd1 << scan_ch;
					if (scan_ch == 0)
						half_sel = ~half_sel;
					for (int i = 0; i < 8; i++)
						r.heater_pins[i] = half_sel ? pat_lo[i][scan_ch] : pat_hi[i][scan_ch];
					r.adc_mux_code = ADC_MUX[scan_ch];
					r.enabled_mask = en_bits;
					slot_results_due.push_back(r);
				end
			endcase
		endfunction

		function void note_mismatch(string field, int unsigned want, int unsigned got);
			errors++;
			$display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h",
				$time, field, want, got);
		endfunction

		function void check_slot_result(rsp_item_t got);
			rsp_item_t want;
			if (slot_results_due.size() == 0) begin
				errors++;
				$display("%0t ns: result with none expected, expected none, actual 'h%0h",
					$time, got);
				return;
			end
			want = slot_results_due.pop_front();
			if (got.heater_pins !== want.heater_pins)
				note_mismatch("heater_pins", want.heater_pins, got.heater_pins);
			if (got.adc_mux_code !== want.adc_mux_code)
				note_mismatch("adc_mux_code", want.adc_mux_code, got.adc_mux_code);
			if (got.enabled_mask !== want.enabled_mask)
				note_mismatch("enabled_mask", want.enabled_mask, got.enabled_mask);
			if (got.overcurrent_trip !== want.overcurrent_trip)
				note_mismatch("overcurrent_trip", want.overcurrent_trip, got.overcurrent_trip);
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	cmd_item_t cmd_data;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp_data;

	// idle chance in percent per cycle, changed per traffic phase
	int send_idle_pct;
	int recv_idle_pct;

	heater_pwm_scoreboard pwm_book = new();

	multichannel_heater_current_pwm_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// safety net against a hung handshake
	initial begin
		#1_000_000;
		$display("** multichannel_heater_current_pwm_unit: FAILED **");
		$finish;
	end

	function automatic cmd_item_t make_cmd(cmd_t c, bit [2:0] ch, bit [15:0] req,
			bit [7:0] smp);
		cmd_item_t it;
		it.command = c;
		it.channel = ch;
		it.current_request = req;
		it.adc_sample = smp;
		return it;
	endfunction

	// random item: mostly ticks with in-range samples so the divide runs often,
	// enough sets and enables to keep channels alive after trips
	function automatic cmd_item_t random_cmd();
		cmd_item_t it;
		int        pick;
		int        k;
		it.channel = 3'($urandom);
		it.current_request = 16'($urandom);
		it.adc_sample = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			it.command = CMD_TICK;
			k = $urandom_range(0, 99);
			// full-range samples give the trips, zero samples the top level
			if (k >= 18)
				it.adc_sample = 8'($urandom_range(1, 63));
			else if (k >= 10)
				it.adc_sample = 8'd0;
		end else if (pick < 75) begin
			it.command = CMD_SET;
			if ($urandom_range(0, 9) == 0)
				it.current_request = 16'd0;
		end else if (pick < 90) begin
			it.command = CMD_ENABLE;
		end else begin
			it.command = CMD_DISABLE;
		end
		return it;
	endfunction

	// present one item at the falling edge, hold it until accepted
	task automatic send_command(cmd_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= it;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		pwm_book.take_command(it);
	endtask

	// result side: sample on the rising edge, decide ready on the falling edge
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready)
				pwm_book.check_slot_result(rsp_data);
			@(negedge clk);
			rsp_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_data = '0;
		send_idle_pct = 35;
		recv_idle_pct = 48;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: first tick after reset checks no channel, even with a tripping sample
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'hff));
		// full-scale request, smallest nonzero target, nonzero request with zero target
		send_command(make_cmd(CMD_SET, 3'd0, 16'hffff, 8'h00));
		send_command(make_cmd(CMD_SET, 3'd1, 16'h0004, 8'h00));
		send_command(make_cmd(CMD_SET, 3'd2, 16'h0003, 8'h00));
		// enable with zero target leaves the low pattern clear
		send_command(make_cmd(CMD_ENABLE, 3'd3, 16'h0000, 8'h00));
		send_command(make_cmd(CMD_SET, 3'd4, 16'h1234, 8'h00));
		// zero request disables
		send_command(make_cmd(CMD_SET, 3'd5, 16'h0000, 8'hff));
		send_command(make_cmd(CMD_DISABLE, 3'd6, 16'hffff, 8'hff));
		send_command(make_cmd(CMD_SET, 3'd7, 16'h8000, 8'h00));
		// two scan passes: low half then high half with the divide,
		// zero sample, largest legal sample, trip thresholds
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h3f));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h01));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h02));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h20));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h05));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h01));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h3f));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h40));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h80));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'hc0));
		send_command(make_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00));

		// random traffic in three phases of back-pressure
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 35;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (300)
				send_command(random_cmd());
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		// drain outstanding tick results, then let trailing activity settle
		while (pwm_book.slot_results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (pwm_book.errors == 0)
			$display("** multichannel_heater_current_pwm_unit: PASSED **");
		else
			$display("** multichannel_heater_current_pwm_unit: FAILED **");
		$finish;
	end

endmodule

// ----- multichannel_heater_current_pwm_unit.f -----
rtl/core/mhcp_pkg.sv
rtl/core/mhcp_div.sv
rtl/core/multichannel_heater_current_pwm_unit.sv
rtl/core/mhcp_checker.sv
tb/tb_multichannel_heater_current_pwm_unit.sv
